@@ sv/aec_pkg.sv @@
// Shared types, constants and register codes for the auto-exposure controller.
package aec_pkg;

    // Field and state widths.
    localparam int LUMA_W  = 8;
    localparam int SUM_W   = 28;
    localparam int CNT_W   = 21;
    localparam int PHASE_W = 8;
    localparam int EXPO_W  = 12;
    localparam int GAIN_W  = 8;
    localparam int MEAN_W  = 16;
    localparam int COEFF_W = 16;
    localparam int PROD_W  = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;

    // Largest value of the saturating sample and byte counters.
    localparam int unsigned CNT_MAX = 32'h001F_FFFF;

    // Restoring divider: one quotient bit per cycle.
    localparam int DIV_STEPS = 16;
    localparam int ITER_W    = 4;

    // Setting limits and reset values.
    localparam logic [EXPO_W-1:0] EXPO_LO    = 12'd4;
    localparam logic [EXPO_W-1:0] EXPO_HI    = 12'd3652;
    localparam logic [EXPO_W-1:0] EXPO_RESET = 12'd800;
    localparam logic [GAIN_W-1:0] GAIN_LO    = 8'd16;
    localparam logic [GAIN_W-1:0] GAIN_HI    = 8'd248;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd100;

    // Register codes, in address order.
    typedef enum logic [2:0] {
        REG_TARGET,
        REG_TOLERANCE,
        REG_STRIDE,
        REG_PLANE,
        REG_GAIN_COEFF,
        REG_GAIN_LIMIT,
        REG_EXPO_COEFF,
        REG_EXPO_LIMIT
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]         target_level;
        logic [7:0]         tolerance_band;
        logic [7:0]         sample_pitch;
        logic [CNT_W-1:0]   plane_size;
        logic [COEFF_W-1:0] gain_coeff;
        logic [7:0]         gain_step_limit;
        logic [COEFF_W-1:0] expo_coeff;
        logic [11:0]        expo_step_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        target_level:    8'd110,
        tolerance_band:  8'd15,
        sample_pitch:    8'd50,
        plane_size:      21'd1024000,
        gain_coeff:      16'd77,
        gain_step_limit: 8'd20,
        expo_coeff:      16'd768,
        expo_step_limit: 12'd200
    };

    // Controller states.
    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DIV,
        ST_DIFF,
        ST_GMUL,
        ST_GUPD,
        ST_EMUL,
        ST_EUPD,
        ST_EMIT
    } aec_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_en;
        logic frame_close;
        logic div_step;
        logic diff_load;
        logic mul_gain;
        logic mul_expo;
        logic gain_upd;
        logic expo_upd;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_zero;
        logic exceed;
        logic gain_same;
    } status_t;

endpackage

@@ sv/aec_regs.sv @@
// APB configuration register file of the auto-exposure controller.
module aec_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [aec_pkg::ADDR_W-1:0] paddr,
    input  logic [aec_pkg::DATA_W-1:0] pwdata,
    output logic [aec_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output aec_pkg::cfg_t              cfg
);
    import aec_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    // Register write decode.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_TARGET:     cfg_next.target_level    = pwdata[7:0];
                REG_TOLERANCE:  cfg_next.tolerance_band  = pwdata[7:0];
                REG_STRIDE:     cfg_next.sample_pitch    = pwdata[7:0];
                REG_PLANE:      cfg_next.plane_size      = pwdata[CNT_W-1:0];
                REG_GAIN_COEFF: cfg_next.gain_coeff      = pwdata[COEFF_W-1:0];
                REG_GAIN_LIMIT: cfg_next.gain_step_limit = pwdata[7:0];
                REG_EXPO_COEFF: cfg_next.expo_coeff      = pwdata[COEFF_W-1:0];
                REG_EXPO_LIMIT: cfg_next.expo_step_limit = pwdata[11:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read mux.
    always_comb begin
        unique case (reg_idx)
            REG_TARGET:     prdata = {24'h0, cfg_reg.target_level};
            REG_TOLERANCE:  prdata = {24'h0, cfg_reg.tolerance_band};
            REG_STRIDE:     prdata = {24'h0, cfg_reg.sample_pitch};
            REG_PLANE:      prdata = {11'h0, cfg_reg.plane_size};
            REG_GAIN_COEFF: prdata = {16'h0, cfg_reg.gain_coeff};
            REG_GAIN_LIMIT: prdata = {24'h0, cfg_reg.gain_step_limit};
            REG_EXPO_COEFF: prdata = {16'h0, cfg_reg.expo_coeff};
            REG_EXPO_LIMIT: prdata = {20'h0, cfg_reg.expo_step_limit};
        endcase
    end

endmodule

@@ sv/aec_datapath.sv @@
// Datapath: luma accumulation, mean divider, proportional steps and result registers.
module aec_datapath #(
    parameter int unsigned MAX_PLANE_BYTES = 1048576
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  aec_pkg::cfg_t              cfg,
    input  aec_pkg::cmd_t              cmd,
    input  logic [aec_pkg::LUMA_W-1:0] s_luma,
    output aec_pkg::status_t           status,
    output logic [aec_pkg::EXPO_W-1:0] m_exposure_out,
    output logic [aec_pkg::GAIN_W-1:0] m_gain_out,
    output logic [aec_pkg::MEAN_W-1:0] m_mean_level,
    output logic                       m_adjusted
);
    import aec_pkg::*;

    // Plane sizes beyond the counter range can never be reached anyway.
    localparam int unsigned CAP_INT =
        (MAX_PLANE_BYTES > CNT_MAX) ? CNT_MAX : MAX_PLANE_BYTES;
    localparam logic [CNT_W-1:0] PLANE_CAP = CAP_INT[CNT_W-1:0];

    // Accumulator state.
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;

    logic [7:0]         stride_eff;
    logic [CNT_W-1:0]   plane_eff;
    logic               in_plane;
    logic               take;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_upd;
    logic [CNT_W-1:0]   cnt_upd;
    logic [CNT_W-1:0]   idx_upd;
    logic [PHASE_W:0]   phase_inc;
    logic [PHASE_W-1:0] phase_upd;

    // Divider state.
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvsr_reg, dvsr_next;
    logic [MEAN_W-1:0] low_reg, low_next;
    logic [MEAN_W-1:0] quo_reg, quo_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_sub;
    logic              trial_ge;

    // Deviation and step state.
    logic [MEAN_W-1:0] mean_reg, mean_next;
    logic [MEAN_W-1:0] adiff_reg, adiff_next;
    logic              neg_reg, neg_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MEAN_W-1:0] mean_w;
    logic [MEAN_W:0]   diff_w;
    logic [MEAN_W:0]   diff_abs;
    logic [COEFF_W-1:0] coeff_sel;
    logic [MEAN_W-1:0] mag;

    // Settings.
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [EXPO_W-1:0] expo_reg, expo_next;
    logic              same_reg, same_next;
    logic [GAIN_W-1:0] gstep;
    logic [EXPO_W-1:0] estep;
    logic signed [GAIN_W+1:0] gsum;
    logic signed [EXPO_W+1:0] esum;
    logic [GAIN_W-1:0] gain_clamp;
    logic [EXPO_W-1:0] expo_clamp;

    // Result registers.
    logic [EXPO_W-1:0] out_expo_reg, out_expo_next;
    logic [GAIN_W-1:0] out_gain_reg, out_gain_next;
    logic [MEAN_W-1:0] out_mean_reg, out_mean_next;
    logic              out_adj_reg, out_adj_next;

    // Sampling of every stride-th byte inside the plane.
    always_comb begin
        stride_eff = (cfg.sample_pitch == 8'd0) ? 8'd1 : cfg.sample_pitch;
        plane_eff  = (cfg.plane_size > PLANE_CAP) ? PLANE_CAP : cfg.plane_size;
        in_plane   = idx_reg < plane_eff;
        take       = in_plane && (phase_reg == '0);
        sum_add    = {1'b0, sum_reg} + {{(SUM_W+1-LUMA_W){1'b0}}, s_luma};
        if (take) begin
            sum_upd = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            cnt_upd = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;
        end else begin
            sum_upd = sum_reg;
            cnt_upd = cnt_reg;
        end
        phase_inc = {1'b0, phase_reg} + 1'b1;
        if (!in_plane) begin
            phase_upd = phase_reg;
        end else if (phase_inc >= {1'b0, stride_eff}) begin
            phase_upd = '0;
        end else begin
            phase_upd = phase_inc[PHASE_W-1:0];
        end
        idx_upd = (&idx_reg) ? idx_reg : idx_reg + 1'b1;
    end

    // Accumulator update; a frame end clears everything after its own byte.
    always_comb begin
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        if (cmd.frame_close) begin
            sum_next   = '0;
            cnt_next   = '0;
            idx_next   = '0;
            phase_next = '0;
        end else if (cmd.acc_en) begin
            sum_next   = sum_upd;
            cnt_next   = cnt_upd;
            idx_next   = idx_upd;
            phase_next = phase_upd;
        end
    end

    assign status.cnt_zero = (cnt_upd == '0);

    // Restoring divider for floor(sum*256/count), saturated to 16 bits.
    always_comb begin
        trial     = {rem_reg, low_reg[MEAN_W-1]};
        trial_sub = trial - {1'b0, dvsr_reg};
        trial_ge  = trial >= {1'b0, dvsr_reg};
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (cmd.frame_close) begin
            rem_next  = {1'b0, sum_upd[SUM_W-1:8]};
            dvsr_next = cnt_upd;
            low_next  = {sum_upd[7:0], 8'h00};
            ovf_next  = {1'b0, sum_upd[SUM_W-1:8]} >= cnt_upd;
        end else if (cmd.div_step) begin
            rem_next = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            low_next = {low_reg[MEAN_W-2:0], 1'b0};
            quo_next = {quo_reg[MEAN_W-2:0], trial_ge};
        end
    end

    // Deviation from the target in Q8.8.
    always_comb begin
        mean_w     = ovf_reg ? {MEAN_W{1'b1}} : quo_reg;
        diff_w     = {1'b0, cfg.target_level, 8'h00} - {1'b0, mean_w};
        diff_abs   = diff_w[MEAN_W] ? (~diff_w + 1'b1) : diff_w;
        mean_next  = mean_reg;
        adiff_next = adiff_reg;
        neg_next   = neg_reg;
        if (cmd.diff_load) begin
            mean_next  = mean_w;
            adiff_next = diff_abs[MEAN_W-1:0];
            neg_next   = diff_w[MEAN_W];
        end
    end

    assign status.exceed = adiff_reg > {cfg.tolerance_band, 8'h00};

    // Shared multiplier for both proportional terms.
    always_comb begin
        coeff_sel = cmd.mul_expo ? cfg.expo_coeff : cfg.gain_coeff;
        prod_next = prod_reg;
        if (cmd.mul_gain || cmd.mul_expo) begin
            prod_next = adiff_reg * coeff_sel;
        end
    end

    assign mag = prod_reg[PROD_W-1:MEAN_W];

    // Gain step, clamped and signed, then the gain range clamp.
    always_comb begin
        gstep = (mag > {8'h00, cfg.gain_step_limit}) ? cfg.gain_step_limit
                                                     : mag[GAIN_W-1:0];
        if (neg_reg) begin
            gsum = $signed({2'b00, gain_reg}) - $signed({2'b00, gstep});
        end else begin
            gsum = $signed({2'b00, gain_reg}) + $signed({2'b00, gstep});
        end
        if (gsum < $signed({2'b00, GAIN_LO})) begin
            gain_clamp = GAIN_LO;
        end else if (gsum > $signed({2'b00, GAIN_HI})) begin
            gain_clamp = GAIN_HI;
        end else begin
            gain_clamp = gsum[GAIN_W-1:0];
        end
    end

    // Exposure step, clamped and signed, then the exposure range clamp.
    always_comb begin
        estep = (mag > {4'h0, cfg.expo_step_limit}) ? cfg.expo_step_limit
                                                    : mag[EXPO_W-1:0];
        if (neg_reg) begin
            esum = $signed({2'b00, expo_reg}) - $signed({2'b00, estep});
        end else begin
            esum = $signed({2'b00, expo_reg}) + $signed({2'b00, estep});
        end
        if (esum < $signed({2'b00, EXPO_LO})) begin
            expo_clamp = EXPO_LO;
        end else if (esum > $signed({2'b00, EXPO_HI})) begin
            expo_clamp = EXPO_HI;
        end else begin
            expo_clamp = esum[EXPO_W-1:0];
        end
    end

    // Setting updates.
    always_comb begin
        gain_next = gain_reg;
        same_next = same_reg;
        expo_next = expo_reg;
        if (cmd.gain_upd) begin
            gain_next = gain_clamp;
            same_next = (gain_clamp == gain_reg);
        end
        if (cmd.expo_upd) begin
            expo_next = expo_clamp;
        end
    end

    assign status.gain_same = same_reg;

    // Result register load.
    always_comb begin
        out_expo_next = out_expo_reg;
        out_gain_next = out_gain_reg;
        out_mean_next = out_mean_reg;
        out_adj_next  = out_adj_reg;
        if (cmd.out_load) begin
            out_expo_next = expo_reg;
            out_gain_next = gain_reg;
            out_mean_next = mean_reg;
            out_adj_next  = status.exceed;
        end
    end

    assign m_exposure_out = out_expo_reg;
    assign m_gain_out     = out_gain_reg;
    assign m_mean_level   = out_mean_reg;
    assign m_adjusted     = out_adj_reg;

    // State with a reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            phase_reg <= '0;
            gain_reg  <= GAIN_RESET;
            expo_reg  <= EXPO_RESET;
        end else begin
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            gain_reg  <= gain_next;
            expo_reg  <= expo_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        dvsr_reg     <= dvsr_next;
        low_reg      <= low_next;
        quo_reg      <= quo_next;
        ovf_reg      <= ovf_next;
        mean_reg     <= mean_next;
        adiff_reg    <= adiff_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        same_reg     <= same_next;
        out_expo_reg <= out_expo_next;
        out_gain_reg <= out_gain_next;
        out_mean_reg <= out_mean_next;
        out_adj_reg  <= out_adj_next;
    end

endmodule

@@ sv/aec_ctrl.sv @@
// Controller state machine sequencing accumulation, division and the control step.
module aec_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_frame_end,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  aec_pkg::status_t  status,
    output aec_pkg::cmd_t     cmd
);
    import aec_pkg::*;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_STEPS - 1);

    aec_state_t        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_ACCUM: begin
                s_ready    = 1'b1;
                cmd.acc_en = s_valid;
                if (s_valid && s_frame_end) begin
                    cmd.frame_close = 1'b1;
                    if (!status.cnt_zero) begin
                        state_next = ST_DIV;
                        iter_next  = '0;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                cmd.diff_load = 1'b1;
                state_next    = ST_GMUL;
            end
            ST_GMUL: begin
                cmd.mul_gain = 1'b1;
                state_next   = status.exceed ? ST_GUPD : ST_EMIT;
            end
            ST_GUPD: begin
                cmd.gain_upd = 1'b1;
                state_next   = ST_EMUL;
            end
            ST_EMUL: begin
                cmd.mul_expo = 1'b1;
                state_next   = status.gain_same ? ST_EUPD : ST_EMIT;
            end
            ST_EUPD: begin
                cmd.expo_upd = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
        endcase
    end

    // Output valid: set on load, cleared when the request is taken.
    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCUM;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/auto_exposure_controller.sv @@
// Auto-exposure controller: luma statistics and proportional gain/exposure control.
// Throughput: one luma byte per cycle while a frame is accumulated.
// After a sampled frame-end byte the input stalls in ST_DIV for the bit-serial divider, then in
// ST_DIFF and ST_GMUL, plus ST_GUPD and ST_EMUL for a gain change and ST_EUPD for an exposure step;
// m_valid rises with s_ready when ST_EMIT loads, later only if the previous result still waits.
// Reset (aresetn low, synchronous) clears the accumulators and restores registers and settings.
module auto_exposure_controller #(
    parameter int unsigned MAX_PLANE_BYTES = 1048576
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [aec_pkg::ADDR_W-1:0] paddr,
    input  logic [aec_pkg::DATA_W-1:0] pwdata,
    output logic [aec_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [aec_pkg::LUMA_W-1:0] s_luma,
    input  logic                       s_frame_end,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [aec_pkg::EXPO_W-1:0] m_exposure_out,
    output logic [aec_pkg::GAIN_W-1:0] m_gain_out,
    output logic [aec_pkg::MEAN_W-1:0] m_mean_level,
    output logic                       m_adjusted
);
    import aec_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // Configuration registers.
    aec_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    aec_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_frame_end (s_frame_end),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Arithmetic and result registers.
    aec_datapath #(
        .MAX_PLANE_BYTES (MAX_PLANE_BYTES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .s_luma         (s_luma),
        .status         (status),
        .m_exposure_out (m_exposure_out),
        .m_gain_out     (m_gain_out),
        .m_mean_level   (m_mean_level),
        .m_adjusted     (m_adjusted)
    );

endmodule

@@ sv/aec_checker.sv @@
// Port-level assertion checker for the auto-exposure controller, with its bind.
module aec_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_frame_end,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [aec_pkg::EXPO_W-1:0] m_exposure_out,
    input logic [aec_pkg::GAIN_W-1:0] m_gain_out,
    input logic [aec_pkg::MEAN_W-1:0] m_mean_level,
    input logic                       m_adjusted
);
    import aec_pkg::*;

    logic [GAIN_W-1:0] last_gain_reg, last_gain_next;
    logic [EXPO_W-1:0] last_expo_reg, last_expo_next;

    // Settings as last delivered on the result channel.
    always_comb begin
        last_gain_next = last_gain_reg;
        last_expo_next = last_expo_reg;
        if (m_valid && m_ready) begin
            last_gain_next = m_gain_out;
            last_expo_next = m_exposure_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_gain_reg <= GAIN_RESET;
            last_expo_reg <= EXPO_RESET;
        end else begin
            last_gain_reg <= last_gain_next;
            last_expo_reg <= last_expo_next;
        end
    end

    // A stalled result request holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_exposure_out) &&
            $stable(m_gain_out) && $stable(m_mean_level) && $stable(m_adjusted))
        else $error("result request changed while stalled");

    // A result without adjustment repeats the settings delivered before it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_adjusted |->
            m_gain_out == last_gain_reg && m_exposure_out == last_expo_reg)
        else $error("settings changed without adjustment");

    // Input is only held off after a frame-end byte was taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_frame_end))
        else $error("input stalled without a frame end");

endmodule

bind auto_exposure_controller aec_checker u_aec_checker (.*);
